// File: hdl/mtep_pkg.sv
// ----------------------------------------------------------------------------
// MIDI track event parser package
// Shared types, phase codes and result kinds.
// ----------------------------------------------------------------------------
package mtep_pkg;

   localparam int TIME_WIDTH = 48;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [3:0] {
      PH_DELTA   = 4'd0,
      PH_STATUS  = 4'd1,
      PH_DATA1   = 4'd2,
      PH_DATA2   = 4'd3,
      PH_MTYPE   = 4'd4,
      PH_MLEN    = 4'd5,
      PH_SLEN    = 4'd6,
      PH_PAYLOAD = 4'd7,
      PH_LSYSEX  = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_SHORT   = 3'd0,
      KIND_HEADER  = 3'd1,
      KIND_PAYLOAD = 3'd2,
      KIND_IGNORED = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   localparam logic [7:0] ST_SYSEX = 8'hf0;
   localparam logic [7:0] ST_EOX   = 8'hf7;
   localparam logic [7:0] ST_META  = 8'hff;
   localparam logic [7:0] META_EOT = 8'h2f;
   localparam logic [TIME_WIDTH-1:0] EOT_TIME = TIME_WIDTH'(32'h0003ffff);

   typedef struct packed {
      logic [7:0] in_byte;
      logic       live_mode;
   } item_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [27:0] delta_time;
      logic [47:0] event_time;
      logic [7:0]  status_byte;
      logic [7:0]  first_data;
      logic [7:0]  second_data;
      logic [27:0] payload_length;
      logic [7:0]  payload_byte;
      logic        last_of_event;
      logic        track_end;
   } result_type;

   function automatic logic two_data(input logic [7:0] s);
      logic [3:0] hi;
      hi = s[7:4];
      return (s == 8'hf2) || (hi != 4'hc && hi != 4'hd && hi != 4'hf);
   endfunction

endpackage

// File: hdl/mtep_queue.sv
// ----------------------------------------------------------------------------
// MIDI track event parser queue
// Two-entry queue between the byte front end and the event engine.
// ----------------------------------------------------------------------------
module mtep_queue
   import mtep_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_ready,
   input  item_type wr_data,
   output logic     rd_valid,
   input  logic     rd_ready,
   output item_type rd_data
);

   item_type   mem_ff [QUEUE_DEPTH];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign wr_ready = (cnt_ff != 2'(QUEUE_DEPTH));
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wp_ff] <= wr_data;
   end

   a_no_over: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count");
   a_pop: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> cnt_ff == $past(cnt_ff) - 2'd1) else $error("count");

endmodule

// File: hdl/mtep_engine.sv
// ----------------------------------------------------------------------------
// MIDI track event parser engine
// Parses one queued byte per cycle, unless stalled, and registers the result.
// ----------------------------------------------------------------------------
module mtep_engine
   import mtep_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  item_type   in_item,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   phase_type              phase_ff, phase_in;
   logic [7:0]             held_ff, held_in, cur_ff, cur_in, fd_ff, fd_in;
   logic [27:0]            dacc_ff, dacc_in, prem_ff, prem_in;
   logic [1:0]             vcnt_ff, vcnt_in;
   logic [TIME_WIDTH-1:0]  tick_ff, tick_in;
   logic                   halt_ff, halt_in;
   logic                   ov_ff, ov_in;
   result_type             res_ff, res_in;
   logic                   step, emit;

   assign out_valid = ov_ff;
   assign out_data  = res_ff;
   assign in_ready  = !ov_ff || out_ready;
   assign step      = in_valid && in_ready;

   always_comb begin
      logic [7:0]  b, s, st;
      logic        lm, again, meta, eot, done, none, ism, last, stop;
      logic [27:0] acc;
      logic [3:0]  k;
      logic [2:0]  kind;
      logic [7:0]  d1, d2, pb;
      logic [27:0] len;
      logic        rl, reot, fin, feot;
      logic        kept;
      b = in_item.in_byte;
      lm = in_item.live_mode;
      phase_in = phase_ff; held_in = held_ff; cur_in = cur_ff; fd_in = fd_ff;
      dacc_in = dacc_ff; prem_in = prem_ff; vcnt_in = vcnt_ff; tick_in = tick_ff;
      halt_in = halt_ff;
      emit = 1'b0; fin = 1'b0; feot = 1'b0; kept = 1'b0;
      kind = KIND_SHORT; st = 8'd0; d1 = 8'd0; d2 = 8'd0; len = 28'd0; pb = 8'd0;
      rl = 1'b0; reot = 1'b0;
      again = 1'b0; s = 8'd0; done = 1'b0; acc = 28'd0; none = 1'b0; ism = 1'b0;
      last = 1'b0; stop = 1'b0; meta = 1'b0; eot = 1'b0;
      res_in.delta_time = 28'd0; res_in.event_time = 48'd0;
      if (!halt_ff) begin
         if (phase_in > PH_LSYSEX) phase_in = PH_DELTA;
         if (lm && phase_in == PH_DELTA) begin
            phase_in = PH_STATUS; dacc_in = 28'd0; vcnt_in = 2'd0;
         end
         for (k = 4'd0; k < 4'd2; k = k + 4'd1) begin
            if (!stop) begin
               again = 1'b0;
               meta = (cur_in == ST_META);
               eot = meta && fd_in == META_EOT;
               case (phase_in)
                  PH_DELTA: begin
                     done = (vcnt_in == 2'd3) || !b[7];
                     dacc_in = {dacc_in[20:0], b[6:0]};
                     vcnt_in = done ? 2'd0 : vcnt_in + 2'd1;
                     if (done) begin
                        tick_in = tick_in + TIME_WIDTH'(dacc_in);
                        phase_in = PH_STATUS;
                     end
                  end
                  PH_STATUS: begin
                     if (!b[7] && held_in == 8'd0) begin
                        emit = 1'b1; kind = KIND_ERROR; d1 = b; rl = 1'b1;
                        halt_in = 1'b1;
                     end else begin
                        if (b[7]) held_in = b;
                        s = b[7] ? b : held_in;
                        cur_in = s;
                        if (s == ST_SYSEX && lm) begin
                           emit = 1'b1; kind = KIND_HEADER; st = s;
                           phase_in = PH_LSYSEX;
                        end else if (s == ST_SYSEX) begin
                           prem_in = 28'd0; vcnt_in = 2'd0; phase_in = PH_SLEN;
                        end else if (s == ST_META && !lm) begin
                           phase_in = PH_MTYPE;
                        end else if (s == 8'hf1 || s == 8'hf2 || s == 8'hf3
                                     || s < ST_SYSEX) begin
                           phase_in = PH_DATA1;
                        end else begin
                           emit = 1'b1; st = s; rl = 1'b1; fin = 1'b1;
                           kind = (s == 8'hf4 || s == 8'hf5 || s == ST_EOX ||
                                   s == 8'hfd) ? KIND_IGNORED : KIND_SHORT;
                        end
                        if (!b[7]) again = !emit || (fin && !lm);
                     end
                  end
                  PH_DATA1: begin
                     if (two_data(cur_in)) begin
                        fd_in = b; phase_in = PH_DATA2;
                     end else begin
                        emit = 1'b1; st = cur_in; d1 = b; rl = 1'b1; fin = 1'b1;
                     end
                  end
                  PH_DATA2: begin
                     st = cur_in;
                     if (st[7:4] == 4'h9 && b == 8'd0) st = {4'h8, st[3:0]};
                     emit = 1'b1; d1 = fd_in; d2 = b; rl = 1'b1; fin = 1'b1;
                  end
                  PH_MTYPE: begin
                     fd_in = b; prem_in = 28'd0; vcnt_in = 2'd0; phase_in = PH_MLEN;
                  end
                  PH_MLEN, PH_SLEN: begin
                     done = (vcnt_in == 2'd3) || !b[7];
                     acc = {prem_in[20:0], b[6:0]};
                     prem_in = acc;
                     vcnt_in = done ? 2'd0 : vcnt_in + 2'd1;
                     if (done) begin
                        none = (acc == 28'd0);
                        ism = (phase_in == PH_MLEN);
                        emit = 1'b1; kind = KIND_HEADER; st = cur_in;
                        d1 = ism ? fd_in : 8'd0; len = acc; rl = none;
                        reot = ism && eot;
                        if (none) begin fin = 1'b1; feot = ism && eot; end
                        else phase_in = PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     prem_in = prem_in - 28'd1;
                     last = (prem_in == 28'd0);
                     emit = 1'b1; kind = KIND_PAYLOAD; st = cur_in;
                     d1 = meta ? fd_in : 8'd0; pb = b; rl = last; reot = eot;
                     fin = last; feot = eot;
                  end
                  default: begin
                     emit = 1'b1; kind = KIND_PAYLOAD; st = cur_in; pb = b;
                     rl = (b == ST_EOX); fin = rl;
                  end
               endcase
               if (emit && !kept) begin
                  res_in.delta_time = (lm || (reot && tick_in == EOT_TIME)) ?
                                      28'd0 : dacc_in;
                  res_in.event_time = 48'(tick_in);
               end
               kept = emit;
               if (fin) begin
                  if (feot) begin held_in = 8'd0; tick_in = '0; end
                  phase_in = lm ? PH_STATUS : PH_DELTA;
                  dacc_in = 28'd0; vcnt_in = 2'd0;
                  fin = 1'b0;
               end
               stop = !again;
            end
         end
      end
      res_in.kind = kind; res_in.status_byte = st; res_in.first_data = d1;
      res_in.second_data = d2; res_in.payload_length = len;
      res_in.payload_byte = pb; res_in.last_of_event = rl;
      res_in.track_end = reot;
      ov_in = step ? emit : (ov_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DELTA; held_ff <= 8'd0; cur_ff <= 8'd0; fd_ff <= 8'd0;
         dacc_ff <= 28'd0; prem_ff <= 28'd0; vcnt_ff <= 2'd0; tick_ff <= '0;
         halt_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         if (step) begin
            phase_ff <= phase_in; held_ff <= held_in; cur_ff <= cur_in;
            fd_ff <= fd_in; dacc_ff <= dacc_in; prem_ff <= prem_in;
            vcnt_ff <= vcnt_in; tick_ff <= tick_in; halt_ff <= halt_in;
         end
      end
      if (step && emit) res_ff <= res_in;
   end

   a_halt: assert property (@(posedge clock) disable iff (reset)
      halt_ff |=> halt_ff) else $error("halt cleared");
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      halt_ff && step |=> !ov_ff || $stable(res_ff)) else $error("result after halt");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !out_ready |=> ov_ff && $stable(res_ff)) else $error("dropped");

endmodule

// File: hdl/midi_track_event_parser.sv
// ----------------------------------------------------------------------------
// MIDI track event parser
// Decodes a MIDI track or live byte stream into events.
// ----------------------------------------------------------------------------
// Usage: bytes enter on req_valid/req_ready, one transaction per byte. They
// go into a two-entry queue; the engine reads one byte per cycle and produces
// at most one result per byte, held in an output register on rsp_valid until
// rsp_ready takes it. The engine takes a new byte in the same cycle that a
// held result is taken, so throughput is one byte per cycle while rsp_ready
// stays high. Each byte is registered in the queue and its result in the
// output register. csr_write_enable writes live_mode; write it only while
// idle. A synchronous reset clears the queue, the output register, running
// status, the timestamp and the error halt, and sets file mode. When the
// receiver stalls, the output holds and the queue fills, then req_ready drops.
// ----------------------------------------------------------------------------
module midi_track_event_parser
   import mtep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [27:0] rsp_delta_time,
   output logic [47:0] rsp_event_time,
   output logic [7:0]  rsp_status_byte,
   output logic [7:0]  rsp_first_data,
   output logic [7:0]  rsp_second_data,
   output logic [27:0] rsp_payload_length,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_of_event,
   output logic        rsp_track_end
);

   logic       live_ff;
   item_type   wr_item, rd_item;
   logic       q_valid, q_ready;
   result_type res;

   always_ff @(posedge clock) begin
      if (reset) live_ff <= 1'b0;
      else if (csr_write_enable) live_ff <= csr_write_data;
   end

   assign wr_item.in_byte   = req_in_byte;
   assign wr_item.live_mode = live_ff;

   mtep_queue u_queue (
      .clock, .reset, .wr_valid(req_valid), .wr_ready(req_ready),
      .wr_data(wr_item), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(rd_item)
   );

   mtep_engine u_engine (
      .clock, .reset, .in_valid(q_valid), .in_ready(q_ready), .in_item(rd_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(res)
   );

   assign rsp_kind           = res.kind;
   assign rsp_delta_time     = res.delta_time;
   assign rsp_event_time     = res.event_time;
   assign rsp_status_byte    = res.status_byte;
   assign rsp_first_data     = res.first_data;
   assign rsp_second_data    = res.second_data;
   assign rsp_payload_length = res.payload_length;
   assign rsp_payload_byte   = res.payload_byte;
   assign rsp_last_of_event  = res.last_of_event;
   assign rsp_track_end      = res.track_end;

endmodule

// File: dv/mtep_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser checker
// Watches the byte, result and register ports and keeps its own model of the
// parser. Each accepted byte queues any event it should produce. Each result
// transaction is compared against the oldest queued event.
// ----------------------------------------------------------------------------
module mtep_checker
   import mtep_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        csr_write_enable,
   input  logic        csr_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_kind,
   input  logic [27:0] rsp_delta_time,
   input  logic [47:0] rsp_event_time,
   input  logic [7:0]  rsp_status_byte,
   input  logic [7:0]  rsp_first_data,
   input  logic [7:0]  rsp_second_data,
   input  logic [27:0] rsp_payload_length,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_last_of_event,
   input  logic        rsp_track_end,
   output int          failures,
   output int          pending,
   output int          events_seen
);

   localparam logic [7:0] ST_TIME_CODE = 8'hf1;
   localparam logic [7:0] ST_SONG_POS  = 8'hf2;
   localparam logic [7:0] ST_SONG_SEL  = 8'hf3;
   localparam logic [7:0] ST_UNDEF_F4  = 8'hf4;
   localparam logic [7:0] ST_UNDEF_F5  = 8'hf5;
   localparam logic [7:0] ST_UNDEF_FD  = 8'hfd;

   result_type expected_events[$];

   logic        live;
   phase_type   phase;
   logic [7:0]  held_status;
   logic [7:0]  cur_status;
   logic [27:0] delta_acc;
   logic [1:0]  vlq_count;
   logic [47:0] ticks;
   logic [7:0]  data_hold;
   logic [27:0] bytes_left;
   logic        halted;

   function automatic void queue_event(input kind_type kind, input logic [7:0] st,
                                       input logic [7:0] d1, input logic [7:0] d2,
                                       input logic [27:0] len, input logic [7:0] pb,
                                       input logic last, input logic eot);
      result_type r;
      r.kind           = kind;
      r.delta_time     = (live || (eot && ticks == EOT_TIME)) ? 28'd0 : delta_acc;
      r.event_time     = ticks;
      r.status_byte    = st;
      r.first_data     = d1;
      r.second_data    = d2;
      r.payload_length = len;
      r.payload_byte   = pb;
      r.last_of_event  = last;
      r.track_end      = eot;
      expected_events.insert(expected_events.size(), r);
   endfunction

   function automatic void end_event(input logic eot);
      if (eot) begin
         held_status = 8'd0;
         ticks = '0;
      end
      phase = live ? PH_STATUS : PH_DELTA;
      delta_acc = '0;
      vlq_count = '0;
   endfunction

   function automatic logic vlq_step(inout logic [27:0] acc, input logic [7:0] b);
      logic done;
      done = (vlq_count == 2'd3) || !b[7];
      acc = {acc[20:0], b[6:0]};
      vlq_count = done ? 2'd0 : vlq_count + 2'd1;
      return done;
   endfunction

   function automatic logic takes_two(input logic [7:0] s);
      return (s == ST_SONG_POS) || (s[7:4] != 4'hc && s[7:4] != 4'hd && s[7:4] != 4'hf);
   endfunction

   function automatic int start_event(input logic [7:0] s);
      cur_status = s;
      case (s)
         ST_SYSEX: begin
            if (live) begin
               queue_event(KIND_HEADER, s, 8'd0, 8'd0, 28'd0, 8'd0, 1'b0, 1'b0);
               phase = PH_LSYSEX;
               return 1;
            end
            bytes_left = '0;
            vlq_count = '0;
            phase = PH_SLEN;
            return 0;
         end
         ST_META: begin
            if (live) begin
               queue_event(KIND_SHORT, s, 8'd0, 8'd0, 28'd0, 8'd0, 1'b1, 1'b0);
               end_event(1'b0);
               return 1;
            end
            phase = PH_MTYPE;
            return 0;
         end
         ST_TIME_CODE, ST_SONG_POS, ST_SONG_SEL: begin
            phase = PH_DATA1;
            return 0;
         end
         ST_UNDEF_F4, ST_UNDEF_F5, ST_EOX, ST_UNDEF_FD: begin
            queue_event(KIND_IGNORED, s, 8'd0, 8'd0, 28'd0, 8'd0, 1'b1, 1'b0);
            end_event(1'b0);
            return 1;
         end
         default: begin
            if (s[7:4] == 4'hf) begin
               queue_event(KIND_SHORT, s, 8'd0, 8'd0, 28'd0, 8'd0, 1'b1, 1'b0);
               end_event(1'b0);
               return 1;
            end
            phase = PH_DATA1;
            return 0;
         end
      endcase
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      int n;
      logic again, meta, eot, last, none, is_meta;
      logic [7:0] st;
      if (halted) return;
      if (live && phase == PH_DELTA) begin
         phase = PH_STATUS;
         delta_acc = '0;
         vlq_count = '0;
      end
      do begin
         again = 1'b0;
         meta = (cur_status == ST_META);
         eot = meta && data_hold == META_EOT;
         case (phase)
            PH_DELTA: begin
               if (vlq_step(delta_acc, b)) begin
                  ticks = ticks + 48'(delta_acc);
                  phase = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (b[7]) begin
                  held_status = b;
                  n = start_event(b);
               end else if (held_status == 8'd0) begin
                  queue_event(KIND_ERROR, 8'd0, b, 8'd0, 28'd0, 8'd0, 1'b1, 1'b0);
                  halted = 1'b1;
               end else begin
                  n = start_event(held_status);
                  again = (n == 0) || (phase == PH_DELTA);
               end
            end
            PH_DATA1: begin
               if (takes_two(cur_status)) begin
                  data_hold = b;
                  phase = PH_DATA2;
               end else begin
                  queue_event(KIND_SHORT, cur_status, b, 8'd0, 28'd0, 8'd0, 1'b1, 1'b0);
                  end_event(1'b0);
               end
            end
            PH_DATA2: begin
               st = cur_status;
               if (st[7:4] == 4'h9 && b == 8'd0) st = {4'h8, st[3:0]};
               queue_event(KIND_SHORT, st, data_hold, b, 28'd0, 8'd0, 1'b1, 1'b0);
               end_event(1'b0);
            end
            PH_MTYPE: begin
               data_hold = b;
               bytes_left = '0;
               vlq_count = '0;
               phase = PH_MLEN;
            end
            PH_MLEN, PH_SLEN: begin
               if (vlq_step(bytes_left, b)) begin
                  none = (bytes_left == 28'd0);
                  is_meta = (phase == PH_MLEN);
                  queue_event(KIND_HEADER, cur_status, is_meta ? data_hold : 8'd0, 8'd0,
                              bytes_left, 8'd0, none, is_meta && eot);
                  if (none) end_event(is_meta && eot);
                  else phase = PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               bytes_left = bytes_left - 28'd1;
               last = (bytes_left == 28'd0);
               queue_event(KIND_PAYLOAD, cur_status, meta ? data_hold : 8'd0, 8'd0,
                           28'd0, b, last, eot);
               if (last) end_event(eot);
            end
            default: begin
               queue_event(KIND_PAYLOAD, cur_status, 8'd0, 8'd0, 28'd0, b, b == ST_EOX,
                           1'b0);
               if (b == ST_EOX) end_event(1'b0);
            end
         endcase
      end while (again);
   endfunction

   always @(posedge clock) begin
      result_type got, exp;
      if (reset) begin
         live = 1'b0;
         phase = PH_DELTA;
         held_status = '0;
         cur_status = '0;
         delta_acc = '0;
         vlq_count = '0;
         ticks = '0;
         data_hold = '0;
         bytes_left = '0;
         halted = 1'b0;
         failures = 0;
         events_seen = 0;
         expected_events.delete();
      end else begin
         if (csr_write_enable) live = csr_write_data;
         if (req_valid && req_ready) predict_byte(req_in_byte);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_kind, rsp_delta_time, rsp_event_time, rsp_status_byte,
                    rsp_first_data, rsp_second_data, rsp_payload_length,
                    rsp_payload_byte, rsp_last_of_event, rsp_track_end};
            events_seen++;
            if (expected_events.size() == 0) begin
               failures++;
               $display("%0t: unexpected result transaction, actual %p", $realtime, got);
            end else begin
               exp = expected_events.pop_front();
               if (got !== exp) begin
                  failures++;
                  $display("%0t: mismatch, expected %p", $realtime, exp);
                  $display("%0t:           actual   %p", $realtime, got);
               end
            end
         end
      end
      pending = expected_events.size();
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MIDI track event parser testbench
// Drives directed and random file tracks and live streams through the parser
// in several mode phases, with bursty input, receiver stalls and a final
// error halt. A checker module predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench
   import mtep_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 3000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        csr_write_enable = 1'b0;
   logic        csr_write_data = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [27:0] rsp_delta_time;
   logic [47:0] rsp_event_time;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_first_data;
   logic [7:0]  rsp_second_data;
   logic [27:0] rsp_payload_length;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_of_event;
   logic        rsp_track_end;
   int          failures, pending, events_seen;

   logic [7:0] stream[$];
   logic [7:0] last_status;
   logic       hold_off = 1'b0;
   int         bytes_sent = 0;
   int         idle_cycles = 0;
   int         cycle_count = 0;

   always #1 clock = ~clock;

   midi_track_event_parser dut (.*);

   mtep_checker u_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout with %0d results outstanding.", pending);
         $display("[midi_track_event_parser] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      wait (bytes_sent >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (200) @(posedge clock);
      hold_off <= 1'b0;
   end

   // The receiver stalls at random, with calm stretches and one long hold-off.
   always @(posedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else if ((cycle_count / 150) % 3 == 1) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic put(input logic [7:0] b);
      stream.insert(stream.size(), b);
   endtask

   task automatic put_vlq(input logic [27:0] v);
      logic [7:0] groups[$];
      groups.push_front({1'b0, v[6:0]});
      v = v >> 7;
      while (v != 0) begin
         groups.push_front({1'b1, v[6:0]});
         v = v >> 7;
      end
      foreach (groups[i]) put(groups[i]);
   endtask

   task automatic put_delta();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) put_vlq(28'($urandom()));
      else if (r == 1) begin
         put(8'hff); put(8'hff); put(8'hff); put(8'($urandom()));
      end else put_vlq(28'($urandom_range(0, 300)));
   endtask

   task automatic put_data(input logic wide);
      put(wide && $urandom_range(0, 7) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 127)));
   endtask

   task automatic put_event(input logic live, input logic noisy);
      int r, len;
      logic [7:0] st;
      r = $urandom_range(0, 99);
      if (!live) put_delta();
      if (r < 55) begin
         st = {4'($urandom_range(8, 14)), 4'($urandom())};
         if (st != last_status || $urandom_range(0, 1) == 0) put(st);
         last_status = st;
         put_data(!live);
         if (st[7:4] != 4'hc && st[7:4] != 4'hd) begin
            if (st[7:4] == 4'h9 && $urandom_range(0, 3) == 0) put(8'd0);
            else put_data(!live);
         end
      end else if (r < 66) begin
         st = 8'($urandom_range(8'hf1, 8'hfe));
         if (st == ST_META) st = 8'hf8;
         put(st);
         last_status = st;
         if (st == 8'hf1 || st == 8'hf3) put_data(!live);
         if (st == 8'hf2) begin put_data(!live); put_data(!live); end
         if (live && st == ST_SYSEX) put(ST_EOX);
         if (!live && st == ST_SYSEX) put(8'd0);
      end else if (r < 78) begin
         len = $urandom_range(0, 6);
         put(ST_SYSEX);
         last_status = ST_SYSEX;
         if (!live) put_vlq(28'(len));
         repeat (len) put(live ? 8'($urandom_range(0, 127)) : 8'($urandom()));
         if (live) put(ST_EOX);
      end else if (r < 92) begin
         put(ST_META);
         last_status = ST_META;
         if (!live) begin
            len = $urandom_range(0, 6);
            put(8'($urandom_range(0, 127)) == META_EOT ? 8'h01 : 8'($urandom_range(0, 127)));
            put_vlq(28'(len));
            repeat (len) put(8'($urandom()));
         end
      end else if (r < 95 && !live) begin
         put(ST_META); put(META_EOT); put(8'd0);
         last_status = 8'd0;
      end else if (noisy) begin
         put(8'($urandom()));
      end else if (last_status[7:4] == 4'hf && last_status != 8'd0) begin
         put(8'($urandom_range(0, 127)));
      end
   endtask

   task automatic send_stream();
      logic ok;
      int burst;
      burst = $urandom_range(1, 30);
      while (stream.size() != 0) begin
         req_valid <= 1'b1;
         req_in_byte <= stream.pop_front();
         do begin
            @(negedge clock);
            ok = req_ready;
            @(posedge clock);
         end while (!ok);
         bytes_sent++;
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 30);
            if ($urandom_range(0, 2) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 8)) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_mode(input logic live);
      csr_write_enable <= 1'b1;
      csr_write_data <= live;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed file track: end of track at the special timestamp, zero
      // velocity note-on, running status, a four-byte delta, undefined and
      // system common statuses, sysex and meta payloads.
      write_mode(1'b0);
      put(8'h8f); put(8'hff); put(8'h7f); put(ST_META); put(META_EOT); put(8'h00);
      put(8'h00); put(8'h90); put(8'h3c); put(8'h00);
      put(8'h05); put(8'h40); put(8'h7f);
      put(8'hff); put(8'hff); put(8'hff); put(8'hff); put(8'hf8);
      put(8'h05); put(8'h90); put(8'h40); put(8'h40);
      put(8'h00); put(8'hf4); put(8'h00); put(8'hf2); put(8'h01); put(8'h02);
      put(8'h00); put(ST_SYSEX); put(8'h02); put(8'haa); put(8'h55);
      put(8'h00); put(ST_META); put(8'h01); put(8'h03); put(8'h41); put(8'h42); put(8'h43);
      put(8'h00); put(ST_META); put(META_EOT); put(8'h00);
      last_status = 8'd0;
      send_stream();
      drain();

      while (bytes_sent + stream.size() < 260) put_event(1'b0, 1'b0);
      put(8'h81);
      send_stream();
      drain();

      write_mode(1'b1);
      last_status = 8'd0;
      put(8'h90); put(8'h40); put(8'h00); put(8'h41); put(8'h7f);
      put(ST_SYSEX); put(8'h01); put(ST_EOX); put(8'h12); put(ST_EOX); put(8'hf5);
      while (bytes_sent + stream.size() < 440) put_event(1'b1, 1'b0);
      send_stream();
      drain();

      write_mode(1'b0);
      while (bytes_sent + stream.size() < 510) put_event(1'b0, 1'b1);
      put(8'h00); put(ST_META); put(META_EOT); put(8'h00);
      put(8'h00); put(8'h45);
      repeat (12) put(8'($urandom()));
      send_stream();
      drain();

      $display("Sent %0d bytes in file, live and file-again phases; checked %0d results.",
               bytes_sent, events_seen);
      if (failures == 0) begin
         $display("[midi_track_event_parser] OK");
      end else begin
         $display("[midi_track_event_parser] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/mtep_pkg.sv
hdl/mtep_queue.sv
hdl/mtep_engine.sv
hdl/midi_track_event_parser.sv
dv/mtep_checker.sv
dv/testbench.sv
